// ----- hw/rtl/utf8_to_utf16_decoder_macros.svh -----
// Assertion macros for the UTF-8 to UTF-16 decoder.
// All checks are sampled on the rising clock edge and are off during reset.
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

// Same-cycle implication.
`define U8U16_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/u8u16_pkg.sv -----
`timescale 1ns / 1ps

package u8u16_pkg;

   // Width of the saturating per-string unit counter.
   localparam int COUNT_WIDTH = 16;

   // Result buffer depth: a four-byte character produces two words.
   localparam int RES_SLOTS = 2;

   // Status codes.
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Open sequence length minus one.
   localparam logic [1:0] SEQ_NONE  = 2'd0;
   localparam logic [1:0] SEQ_TWO   = 2'd1;
   localparam logic [1:0] SEQ_THREE = 2'd2;
   localparam logic [1:0] SEQ_FOUR  = 2'd3;

   // Continuation byte tag in bits 7:6.
   localparam logic [1:0] CONT_TAG = 2'b10;

   // Scalar limits.
   localparam logic [20:0] MIN_TWO      = 21'h00080;
   localparam logic [20:0] MIN_THREE    = 21'h00800;
   localparam logic [20:0] SURR_LOW     = 21'h0D800;
   localparam logic [20:0] SURR_END     = 21'h0E000;
   localparam logic [20:0] MIN_FOUR     = 21'h10000;
   localparam logic [20:0] MAX_SCALAR   = 21'h10FFFF;

   // Surrogate bases.
   localparam logic [15:0] HI_SURR_BASE = 16'hD800;
   localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        status;
      logic [15:0] unit_count;
      logic        final_res;
   } res_type;

   // Decoder view of the byte in the input register.
   typedef struct packed {
      logic [1:0] count;   // words this byte produces, 0 to 2
      res_type    first;
      res_type    second;
   } dec_out_type;

   function automatic count_type sat_inc(count_type c);
      count_type r;
      r = (c == '1) ? c : COUNT_WIDTH'(c + 1'b1);
      return r;
   endfunction

endpackage

// ----- hw/rtl/u8u16_core.sv -----
`timescale 1ns / 1ps

// Per-string decode state and the single-pass decode of one byte.
module u8u16_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             in_byte,
   input  logic                   in_eos,
   input  logic                   commit,
   output u8u16_pkg::dec_out_type dec
);

   logic [1:0]             pend_ff, pend_in;
   logic [1:0]             len_ff, len_in;
   logic [20:0]            acc_ff, acc_in;
   logic                   disc_ff, disc_in;
   u8u16_pkg::count_type   cnt_ff, cnt_in;

   logic [20:0]            acc_shift;
   logic [19:0]            offs;
   logic                   err;
   logic [1:0]             emit;
   logic [15:0]            u0, u1;
   u8u16_pkg::count_type   c1, c2;

   assign acc_shift = {acc_ff[14:0], in_byte[5:0]};
   assign offs      = 20'(acc_shift - u8u16_pkg::MIN_FOUR);
   assign c1        = u8u16_pkg::sat_inc(cnt_ff);
   assign c2        = u8u16_pkg::sat_inc(c1);

   always_comb begin
      pend_in = pend_ff;
      len_in  = len_ff;
      acc_in  = acc_ff;
      disc_in = disc_ff;
      cnt_in  = cnt_ff;
      err     = 1'b0;
      emit    = 2'd0;
      u0      = 16'h0000;
      u1      = 16'h0000;

      if (!disc_ff) begin
         if (pend_ff == 2'd0) begin
            unique case (in_byte) inside
               [8'h00:8'h7F]: begin
                  emit = 2'd1;
                  u0   = {8'h00, in_byte};
               end
               [8'h80:8'hBF]: err = 1'b1;
               [8'hC0:8'hDF]: begin
                  pend_in = 2'd1;
                  len_in  = u8u16_pkg::SEQ_TWO;
                  acc_in  = {16'h0000, in_byte[4:0]};
               end
               [8'hE0:8'hEF]: begin
                  pend_in = 2'd2;
                  len_in  = u8u16_pkg::SEQ_THREE;
                  acc_in  = {17'h00000, in_byte[3:0]};
               end
               [8'hF0:8'hF7]: begin
                  pend_in = 2'd3;
                  len_in  = u8u16_pkg::SEQ_FOUR;
                  acc_in  = {18'h00000, in_byte[2:0]};
               end
               default: err = 1'b1;
            endcase
         end else if (in_byte[7:6] != u8u16_pkg::CONT_TAG) begin
            err = 1'b1;
         end else begin
            acc_in  = acc_shift;
            pend_in = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               len_in = u8u16_pkg::SEQ_NONE;
               acc_in = 21'h000000;
               unique case (len_ff)
                  u8u16_pkg::SEQ_TWO: begin
                     if (acc_shift < u8u16_pkg::MIN_TWO) begin
                        err = 1'b1;
                     end else begin
                        emit = 2'd1;
                        u0   = acc_shift[15:0];
                     end
                  end
                  u8u16_pkg::SEQ_THREE: begin
                     if (acc_shift < u8u16_pkg::MIN_THREE ||
                         (acc_shift >= u8u16_pkg::SURR_LOW &&
                          acc_shift < u8u16_pkg::SURR_END)) begin
                        err = 1'b1;
                     end else begin
                        emit = 2'd1;
                        u0   = acc_shift[15:0];
                     end
                  end
                  default: begin
                     if (acc_shift < u8u16_pkg::MIN_FOUR ||
                         acc_shift > u8u16_pkg::MAX_SCALAR) begin
                        err = 1'b1;
                     end else begin
                        emit = 2'd2;
                        u0   = u8u16_pkg::HI_SURR_BASE + {6'h00, offs[19:10]};
                        u1   = u8u16_pkg::LO_SURR_BASE + {6'h00, offs[9:0]};
                     end
                  end
               endcase
            end
         end

         // truncated sequence at the end mark
         if (!err && in_eos && pend_in != 2'd0) begin
            err = 1'b1;
         end

         if (err) begin
            pend_in = 2'd0;
            len_in  = u8u16_pkg::SEQ_NONE;
            acc_in  = 21'h000000;
            disc_in = !in_eos;
         end else if (emit == 2'd2) begin
            cnt_in = c2;
         end else if (emit == 2'd1) begin
            cnt_in = c1;
         end
      end

      if (in_eos) begin
         pend_in = 2'd0;
         len_in  = u8u16_pkg::SEQ_NONE;
         acc_in  = 21'h000000;
         disc_in = 1'b0;
         cnt_in  = '0;
      end
   end

   always_comb begin
      dec.count = err ? 2'd1 : emit;

      dec.first.code_unit  = err ? 16'h0000 : u0;
      dec.first.status     = err ? u8u16_pkg::STATUS_ERR : u8u16_pkg::STATUS_OK;
      dec.first.unit_count = err ? 16'(cnt_ff) : 16'(c1);
      dec.first.final_res  = err || (in_eos && emit == 2'd1);

      dec.second.code_unit  = u1;
      dec.second.status     = u8u16_pkg::STATUS_OK;
      dec.second.unit_count = 16'(c2);
      dec.second.final_res  = in_eos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
         len_ff  <= u8u16_pkg::SEQ_NONE;
         acc_ff  <= 21'h000000;
         disc_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (commit) begin
         pend_ff <= pend_in;
         len_ff  <= len_in;
         acc_ff  <= acc_in;
         disc_ff <= disc_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ----- hw/rtl/utf8_to_utf16_decoder.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Ports                                         Word
// req      in   req_valid req_ready req_data_byte             one UTF-8 byte
//               req_end_of_string                             + end mark
// rsp      out  rsp_valid rsp_ready rsp_code_unit rsp_status  one UTF-16 unit
//               rsp_unit_count rsp_final_res                  or an error
//
// One byte per cycle is accepted while the input register is free or passes its
// byte on. A byte is held in the input register, is decoded into the two-slot
// result buffer and appears on rsp from the buffer head. A four-byte character
// gives two words and needs both buffer slots free after the current pop, so
// input waits when a pair arrives behind a waiting word. Reset is synchronous
// and clears the string state and all valid flags; rsp stalls back up through
// the buffer into the input register.

`include "utf8_to_utf16_decoder_macros.svh"

module utf8_to_utf16_decoder (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_string,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_status,
   output logic [15:0] rsp_unit_count,
   output logic        rsp_final_res
);

   // input register
   logic                   in_vld_ff, in_vld_in;
   logic [7:0]             in_byte_ff;
   logic                   in_eos_ff;

   // result buffer, slot 0 is the head shown on rsp
   logic [u8u16_pkg::RES_SLOTS-1:0] o_vld_ff, o_vld_in;
   u8u16_pkg::res_type              o_res_ff [u8u16_pkg::RES_SLOTS];
   u8u16_pkg::res_type              o_res_in [u8u16_pkg::RES_SLOTS];
   u8u16_pkg::res_type              kept     [u8u16_pkg::RES_SLOTS];
   u8u16_pkg::res_type              fresh    [u8u16_pkg::RES_SLOTS];

   u8u16_pkg::dec_out_type dec;
   logic                   pop;
   logic                   commit;
   logic [1:0]             occ;
   logic [1:0]             base;
   logic [1:0]             free;

   u8u16_core u_core (
      .clock   (clock),
      .reset   (reset),
      .in_byte (in_byte_ff),
      .in_eos  (in_eos_ff),
      .commit  (commit),
      .dec     (dec)
   );

   assign pop    = o_vld_ff[0] && rsp_ready;
   assign occ    = {1'b0, o_vld_ff[0]} + {1'b0, o_vld_ff[1]};
   assign base   = occ - {1'b0, pop};
   assign free   = 2'd2 - base;
   // the byte leaves the input register once all its words fit
   assign commit = in_vld_ff && (dec.count <= free);

   assign req_ready = !in_vld_ff || commit;
   assign in_vld_in = (req_valid && req_ready) || (in_vld_ff && !commit);

   assign kept[0]  = pop ? o_res_ff[1] : o_res_ff[0];
   assign kept[1]  = o_res_ff[1];
   assign fresh[0] = dec.first;
   assign fresh[1] = dec.second;

   // surviving words stay in order at the front, new words fill behind them
   always_comb begin
      logic [1:0] pos;
      for (int i = 0; i < u8u16_pkg::RES_SLOTS; i++) begin
         pos = 2'(i) - base;
         if (2'(i) < base) begin
            o_vld_in[i] = 1'b1;
            o_res_in[i] = kept[i];
         end else begin
            o_vld_in[i] = commit && (pos < dec.count);
            o_res_in[i] = fresh[pos[0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         o_vld_ff  <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         o_vld_ff  <= o_vld_in;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eos_ff  <= req_end_of_string;
      end
      o_res_ff[0] <= o_res_in[0];
      o_res_ff[1] <= o_res_in[1];
   end

   assign rsp_valid      = o_vld_ff[0];
   assign rsp_code_unit  = o_res_ff[0].code_unit;
   assign rsp_status     = o_res_ff[0].status;
   assign rsp_unit_count = o_res_ff[0].unit_count;
   assign rsp_final_res  = o_res_ff[0].final_res;

   // buffer fills from the head
   `U8U16_ASSERT_NOW(a_buf_order, o_vld_ff[1], o_vld_ff[0], "result buffer has a hole")
   // an error word is always zero and closes the string
   `U8U16_ASSERT_NOW(a_err_word,
      rsp_valid && rsp_status == u8u16_pkg::STATUS_ERR,
      rsp_code_unit == 16'h0000 && rsp_final_res, "malformed error word")
   // a high surrogate at the head always has its low half right behind it
   `U8U16_ASSERT_NOW(a_pair_kept,
      rsp_valid && rsp_status == u8u16_pkg::STATUS_OK && rsp_code_unit[15:10] == 6'b110110,
      o_vld_ff[1] && o_res_ff[1].code_unit[15:10] == 6'b110111, "surrogate pair split")
   // a stalled head word is held
   `U8U16_ASSERT_NEXT(a_head_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_code_unit) && $stable(rsp_unit_count), "head word lost")

endmodule

// ----- tb/utf8_stream_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the decoder, predicts the UTF-16 words for each
// accepted byte and compares them in order against the rsp side.
module utf8_stream_checker (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_string,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_code_unit,
   input  logic        rsp_status,
   input  logic [15:0] rsp_unit_count,
   input  logic        rsp_final_res,

   output int          fail_count,
   output int          words_waiting,
   output int          words_checked,
   output int          error_words
);

   // decoder state, kept apart from the DUT
   logic [1:0]            left_cont;
   logic [1:0]            seq_len;
   logic [20:0]           scalar_acc;
   logic                  dropping;
   u8u16_pkg::count_type  str_units;

   u8u16_pkg::res_type    expected_words[$];
   u8u16_pkg::res_type    want;
   int                    fails;
   int                    seen;
   int                    errs;
   logic                  bad_word;

   initial begin
      left_cont  = '0;
      seq_len    = u8u16_pkg::SEQ_NONE;
      scalar_acc = '0;
      dropping   = 1'b0;
      str_units  = '0;
      fails      = 0;
      seen       = 0;
      errs       = 0;
   end

   task automatic clear_string();
      left_cont  = '0;
      seq_len    = u8u16_pkg::SEQ_NONE;
      scalar_acc = '0;
      dropping   = 1'b0;
      str_units  = '0;
   endtask

   task automatic push_unit(input logic [15:0] unit);
      u8u16_pkg::res_type w;
      if (str_units != '1)
         str_units = str_units + 1'b1;
      w.code_unit  = unit;
      w.status     = u8u16_pkg::STATUS_OK;
      w.unit_count = 16'(str_units);
      w.final_res  = 1'b0;
      expected_words.push_back(w);
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic eos);
      logic               bad;
      int                 first_new;
      logic [20:0]        s;
      logic [20:0]        v;
      u8u16_pkg::res_type w;
      bad       = 1'b0;
      first_new = expected_words.size();
      if (dropping) begin
         // after an error, only the end mark matters
         if (eos)
            clear_string();
      end else begin
         if (left_cont == 2'd0) begin
            if (b < 8'h80) begin
               push_unit({8'h00, b});
            end else if (b < 8'hC0) begin
               bad = 1'b1;                      // stray continuation
            end else if (b < 8'hE0) begin
               left_cont  = 2'd1;
               seq_len    = u8u16_pkg::SEQ_TWO;
               scalar_acc = 21'(b[4:0]);
            end else if (b < 8'hF0) begin
               left_cont  = 2'd2;
               seq_len    = u8u16_pkg::SEQ_THREE;
               scalar_acc = 21'(b[3:0]);
            end else if (b < 8'hF8) begin
               left_cont  = 2'd3;
               seq_len    = u8u16_pkg::SEQ_FOUR;
               scalar_acc = 21'(b[2:0]);
            end else begin
               bad = 1'b1;                      // lead F8..FF
            end
         end else if (b[7:6] != u8u16_pkg::CONT_TAG) begin
            bad = 1'b1;
         end else begin
            scalar_acc = {scalar_acc[14:0], b[5:0]};
            left_cont  = left_cont - 2'd1;
            if (left_cont == 2'd0) begin
               s = scalar_acc;
               case (seq_len)
                  u8u16_pkg::SEQ_TWO: begin
                     if (s < u8u16_pkg::MIN_TWO)
                        bad = 1'b1;
                     else
                        push_unit(s[15:0]);
                  end
                  u8u16_pkg::SEQ_THREE: begin
                     if (s < u8u16_pkg::MIN_THREE ||
                         (s >= u8u16_pkg::SURR_LOW && s < u8u16_pkg::SURR_END))
                        bad = 1'b1;
                     else
                        push_unit(s[15:0]);
                  end
                  default: begin
                     if (s < u8u16_pkg::MIN_FOUR || s > u8u16_pkg::MAX_SCALAR) begin
                        bad = 1'b1;
                     end else begin
                        v = s - u8u16_pkg::MIN_FOUR;
                        push_unit(u8u16_pkg::HI_SURR_BASE + 16'(v[19:10]));
                        push_unit(u8u16_pkg::LO_SURR_BASE + 16'(v[9:0]));
                     end
                  end
               endcase
               seq_len    = u8u16_pkg::SEQ_NONE;
               scalar_acc = '0;
            end
         end

         // end mark in the middle of a sequence
         if (!bad && eos && left_cont != 2'd0)
            bad = 1'b1;

         if (bad) begin
            w.code_unit  = '0;
            w.status     = u8u16_pkg::STATUS_ERR;
            w.unit_count = 16'(str_units);
            w.final_res  = 1'b1;
            expected_words.push_back(w);
            clear_string();
            dropping = !eos;
         end else if (eos) begin
            if (expected_words.size() > first_new) begin
               w = expected_words.pop_back();
               w.final_res = 1'b1;
               expected_words.push_back(w);
            end
            clear_string();
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_string();
         expected_words.delete();
      end else begin
         // words leave before this edge's byte is added: a byte never
         // produces a word in its own cycle
         if (rsp_valid && rsp_ready) begin
            seen++;
            if (rsp_status == u8u16_pkg::STATUS_ERR)
               errs++;
            if (expected_words.size() == 0) begin
               fails++;
               $display("%0t unexpected word: expected none, got %h %b %0d %b",
                        $time, rsp_code_unit, rsp_status, rsp_unit_count, rsp_final_res);
            end else begin
               want     = expected_words.pop_front();
               bad_word = 1'b0;
               if (rsp_code_unit !== want.code_unit) begin
                  bad_word = 1'b1;
                  $display("%0t code_unit mismatch: expected %h, got %h",
                           $time, want.code_unit, rsp_code_unit);
               end
               if (rsp_status !== want.status) begin
                  bad_word = 1'b1;
                  $display("%0t status mismatch: expected %b, got %b",
                           $time, want.status, rsp_status);
               end
               if (rsp_unit_count !== want.unit_count) begin
                  bad_word = 1'b1;
                  $display("%0t unit_count mismatch: expected %0d, got %0d",
                           $time, want.unit_count, rsp_unit_count);
               end
               if (rsp_final_res !== want.final_res) begin
                  bad_word = 1'b1;
                  $display("%0t final_res mismatch: expected %b, got %b",
                           $time, want.final_res, rsp_final_res);
               end
               if (bad_word)
                  fails++;
            end
         end
         if (req_valid && req_ready)
            predict_byte(req_data_byte, req_end_of_string);
      end
      fail_count    <= fails;
      words_waiting <= expected_words.size();
      words_checked <= seen;
      error_words   <= errs;
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Top of the decoder bench: clock, reset, byte stimulus, rsp back-pressure,
// watchdog and the verdict. Prediction and comparison live in the checker.
module tb_top;

   localparam int HOLD_CYCLES    = 200;   // long rsp hold-off, fills the DUT
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving
   localparam int DRAIN_TAIL     = 10;    // extra cycles after the last word
   localparam int PHASE_BYTES    = 100;   // random bytes per flow phase

   // malformations injected into otherwise well-formed strings
   typedef enum int {
      FAULT_NONE,
      FAULT_STRAY,
      FAULT_BAD_LEAD,
      FAULT_OVERLONG,
      FAULT_SURROGATE,
      FAULT_BEYOND,
      FAULT_BAD_CONT,
      FAULT_TRUNCATED
   } fault_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_string = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_code_unit;
   logic        rsp_status;
   logic [15:0] rsp_unit_count;
   logic        rsp_final_res;

   int          chk_fails;
   int          chk_waiting;
   int          chk_words;
   int          chk_errors;

   // flow control knobs, percent of cycles spent idle / stalled
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   // one-shot long hold-off on rsp, requested by the stimulus
   logic        hold_req = 1'b0;
   logic        hold_taken = 1'b0;
   int          hold_left = 0;

   int          idle_cycles = 0;
   int          bytes_sent = 0;
   int          strings_sent = 0;
   int          phase_bytes = 0;

   logic [7:0]  str_q[$];   // bytes of the string being sent

   always #5 clock = ~clock;

   utf8_to_utf16_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_status        (rsp_status),
      .rsp_unit_count    (rsp_unit_count),
      .rsp_final_res     (rsp_final_res)
   );

   utf8_stream_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_status        (rsp_status),
      .rsp_unit_count    (rsp_unit_count),
      .rsp_final_res     (rsp_final_res),
      .fail_count        (chk_fails),
      .words_waiting     (chk_waiting),
      .words_checked     (chk_words),
      .error_words       (chk_errors)
   );

   // Receiver: random stalls per phase, plus one long hold-off counted here.
   always @(posedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog: any word moving on either channel resets the count.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no word moved for %0d cycles, %0d words still due",
                     $time, idle_cycles, chk_waiting);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Append the UTF-8 form of a scalar in n bytes. Any scalar fits any
   // length the lead allows, which is how overlong and out-of-range forms
   // get built.
   task automatic put_scalar(input logic [20:0] v, input int n);
      case (n)
         1: str_q.push_back(v[7:0]);
         2: begin
            str_q.push_back({3'b110, v[10:6]});
            str_q.push_back({u8u16_pkg::CONT_TAG, v[5:0]});
         end
         3: begin
            str_q.push_back({4'b1110, v[15:12]});
            str_q.push_back({u8u16_pkg::CONT_TAG, v[11:6]});
            str_q.push_back({u8u16_pkg::CONT_TAG, v[5:0]});
         end
         default: begin
            str_q.push_back({5'b11110, v[20:18]});
            str_q.push_back({u8u16_pkg::CONT_TAG, v[17:12]});
            str_q.push_back({u8u16_pkg::CONT_TAG, v[11:6]});
            str_q.push_back({u8u16_pkg::CONT_TAG, v[5:0]});
         end
      endcase
   endtask

   // Build one random string: mostly well-formed characters, some with a
   // single malformation, now and then plain byte noise.
   task automatic make_string();
      int             nchar;
      int             where;
      int             len;
      fault_kind_type fault;
      logic [20:0]    v;
      logic [7:0]     junk;
      str_q.delete();
      if ($urandom_range(0, 9) == 0) begin
         len = $urandom_range(1, 6);
         repeat (len) str_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         nchar = $urandom_range(1, 6);
         fault = FAULT_NONE;
         if ($urandom_range(0, 99) < 30)
            fault = fault_kind_type'($urandom_range(FAULT_STRAY, FAULT_TRUNCATED));
         // a truncated sequence only makes sense at the end mark
         where = (fault == FAULT_TRUNCATED) ? nchar - 1 : $urandom_range(0, nchar - 1);
         for (int i = 0; i < nchar; i++) begin
            if (fault == FAULT_NONE || i != where) begin
               len = $urandom_range(1, 4);
               case (len)
                  1: v = 21'($urandom_range(0, 21'h7F));
                  2: v = 21'($urandom_range(u8u16_pkg::MIN_TWO, u8u16_pkg::MIN_THREE - 1));
                  3: begin
                     v = 21'($urandom_range(u8u16_pkg::MIN_THREE, u8u16_pkg::MIN_FOUR - 1));
                     if (v >= u8u16_pkg::SURR_LOW && v < u8u16_pkg::SURR_END)
                        v = v - 21'h800;
                  end
                  default: v = 21'($urandom_range(u8u16_pkg::MIN_FOUR,
                                                  u8u16_pkg::MAX_SCALAR));
               endcase
               put_scalar(v, len);
            end else begin
               case (fault)
                  FAULT_STRAY: begin
                     str_q.push_back({u8u16_pkg::CONT_TAG, 6'($urandom_range(0, 63))});
                  end
                  FAULT_BAD_LEAD: str_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
                  FAULT_OVERLONG: begin
                     len = $urandom_range(2, 4);
                     if (len == 2)
                        v = 21'($urandom_range(0, u8u16_pkg::MIN_TWO - 1));
                     else if (len == 3)
                        v = 21'($urandom_range(0, u8u16_pkg::MIN_THREE - 1));
                     else
                        v = 21'($urandom_range(0, u8u16_pkg::MIN_FOUR - 1));
                     put_scalar(v, len);
                  end
                  FAULT_SURROGATE: begin
                     v = 21'($urandom_range(u8u16_pkg::SURR_LOW, u8u16_pkg::SURR_END - 1));
                     put_scalar(v, 3);
                  end
                  FAULT_BEYOND: begin
                     v = 21'($urandom_range(u8u16_pkg::MAX_SCALAR + 1, 21'h1FFFFF));
                     put_scalar(v, 4);
                  end
                  FAULT_BAD_CONT: begin
                     // cut a sequence short and follow with a non-10xxxxxx byte
                     len = $urandom_range(2, 4);
                     put_scalar(21'($urandom_range(0, 21'h1FFFFF)), len);
                     repeat ($urandom_range(1, len - 1)) void'(str_q.pop_back());
                     junk = 8'($urandom_range(0, 255));
                     if (junk[7:6] == u8u16_pkg::CONT_TAG)
                        junk[6] = 1'b1;
                     str_q.push_back(junk);
                  end
                  default: begin
                     len = $urandom_range(2, 4);
                     put_scalar(21'($urandom_range(0, 21'h1FFFFF)), len);
                     repeat ($urandom_range(1, len - 1)) void'(str_q.pop_back());
                  end
               endcase
            end
         end
      end
   endtask

   // Offer str_q byte by byte, end mark on the last. Valid stays up between
   // back-to-back bytes; it only drops on an idle cycle.
   task automatic send_string();
      for (int i = 0; i < str_q.size(); i++) begin
         while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid         <= 1'b1;
         req_data_byte     <= str_q[i];
         req_end_of_string <= (i == str_q.size() - 1);
         @(posedge clock);
         while (!req_ready)
            @(posedge clock);
         bytes_sent++;
         phase_bytes++;
      end
      strings_sent++;
   endtask

   // Sender goes quiet until every predicted word has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (chk_waiting != 0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: both one-byte ends, lowest two-byte, highest three- and four-byte scalars,
      // a surrogate pair closing a string, then one string per kind of malformed input.
      str_q = '{8'h00, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_string();
      str_q = '{8'h7F};
      send_string();
      str_q = '{8'h80};                       // stray continuation with end mark
      send_string();
      str_q = '{8'hFF, 8'h41};                // bad lead, then dropped byte
      send_string();
      str_q = '{8'hC1, 8'hBF};                // overlong two-byte
      send_string();
      str_q = '{8'hED, 8'hA0, 8'h80};         // encoded surrogate
      send_string();
      str_q = '{8'hF4, 8'h90, 8'h80, 8'h80};  // above 10FFFF
      send_string();
      str_q = '{8'hC2, 8'hC2};                // bad continuation
      send_string();
      str_q = '{8'hE2};                       // truncated at end mark
      send_string();
      wait_drained();

      // Random: four flow phases. Phase 0 runs flat out and takes the long
      // hold-off on rsp partway, so the DUT backs up into req.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 77; end
            default: begin send_idle_pct = 25; recv_stall_pct <= 25; end
         endcase
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            if (ph == 0 && phase_bytes >= 20)
               hold_req <= 1'b1;
            make_string();
            send_string();
         end
         wait_drained();
      end

      repeat (DRAIN_TAIL) @(posedge clock);

      $display("covered %0d bytes in %0d strings, directed cases and four flow phases",
               bytes_sent, strings_sent);
      $display("checked %0d words, %0d of them error words", chk_words, chk_errors);
      if (chk_fails == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_core.sv
hw/rtl/utf8_to_utf16_decoder.sv
tb/utf8_stream_checker.sv
tb/tb_top.sv
